FILE: sv/uart_rx_line_buffer_ring_defines.svh
// Assertion macros for the receive line buffer ring checker.
// Expects aclk and aresetn in the scope of each use.
`ifndef UART_RX_LINE_BUFFER_RING_DEFINES_SVH
`define UART_RX_LINE_BUFFER_RING_DEFINES_SVH

// same-cycle implication
`define URLBR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("urlbr assertion failed");

// next-cycle implication
`define URLBR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("urlbr assertion failed");

`endif

FILE: sv/urlbr_pkg.sv
// Package for the receive line buffer ring: register codes, reset values,
// port widths. No dependencies.
`default_nettype none

package urlbr_pkg;

    localparam int DEF_MAX_LINE_BYTES = 64;
    localparam int DEF_MAX_LINES      = 8;

    localparam int LINE_SIZE_RESET  = 48;
    localparam int LINE_COUNT_RESET = 4;
    localparam int EOL_CHAR_RESET   = 13;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_SIZE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LINE_COUNT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EOL_CHAR   = 2'd2;

    localparam int BYTE_W       = 8;
    localparam int LEN_FIELD_W  = 7;
    localparam int SLOT_FIELD_W = 3;
    localparam int OUT_TDATA_W  = 24;
    localparam int OUT_PAD_W    = OUT_TDATA_W - BYTE_W - LEN_FIELD_W - SLOT_FIELD_W;

    localparam logic KIND_RX   = 1'b0;
    localparam logic KIND_TAKE = 1'b1;

endpackage

`default_nettype wire

FILE: sv/urlbr_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module urlbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: sv/uart_rx_line_buffer_ring.sv
// Top level of the receive line buffer ring.
// Depends on urlbr_pkg and urlbr_ram.
`default_nettype none

// A receive request (tuser 0) stores one byte; a line closes on the end-of-line
// byte or when it reaches the configured line size, and the writer moves on to
// the next slot, overwriting unread lines. A take request (tuser 1) answers
// with one none-ready result, or fetches the line length from the length memory
// through the ST_LEN state and then streams the line at one byte per cycle, set
// by the single read port of the line store and slowed only by m_tready. New
// requests are held off until the last byte of a run has left the read stage.
// Configuration writes are always ready.
module uart_rx_line_buffer_ring #(
    parameter int MAX_LINE_BYTES = urlbr_pkg::DEF_MAX_LINE_BYTES,
    parameter int MAX_LINES      = urlbr_pkg::DEF_MAX_LINES
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [urlbr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [urlbr_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,   // rx_byte
    input  wire logic                               s_tuser,   // kind
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic      [urlbr_pkg::OUT_TDATA_W-1:0]  m_tdata,   // line_byte, line_length, line_slot, pad
    output logic                                    m_tuser,   // none_ready
    output logic                                    m_tlast    // last_byte
);

    import urlbr_pkg::*;

    localparam int DEPTH  = MAX_LINES * MAX_LINE_BYTES;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SLOT_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int CNT_W  = $clog2(MAX_LINES + 1);
    localparam int OFF_W  = (MAX_LINE_BYTES > 1) ? $clog2(MAX_LINE_BYTES) : 1;
    localparam int LEN_W  = $clog2(MAX_LINE_BYTES + 1);

    localparam int RST_SIZE  = (LINE_SIZE_RESET > MAX_LINE_BYTES) ? MAX_LINE_BYTES
                                                                   : LINE_SIZE_RESET;
    localparam int RST_COUNT = (LINE_COUNT_RESET > MAX_LINES) ? MAX_LINES : LINE_COUNT_RESET;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LEN    = 2'd1;
    localparam logic [1:0] ST_STREAM = 2'd2;

    logic [LEN_W-1:0]  size_reg,  size_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [7:0]        eol_reg,   eol_next;

    logic [1:0]        state_reg, state_next;
    logic [SLOT_W-1:0] wslot_reg, wslot_next;
    logic [OFF_W-1:0]  woff_reg,  woff_next;
    logic [SLOT_W-1:0] rslot_reg, rslot_next;
    logic [MAX_LINES-1:0] valid_reg, valid_next;
    logic [SLOT_W-1:0] oslot_reg, oslot_next;
    logic [LEN_W-1:0]  len_reg,   len_next;
    logic [LEN_W-1:0]  k_reg,     k_next;

    logic              p_vld_reg,  p_vld_next;
    logic              p_none_reg, p_none_next;
    logic              p_last_reg, p_last_next;

    logic              m_vld_reg,  m_vld_next;
    logic              m_none_reg, m_none_next;
    logic              m_last_reg, m_last_next;
    logic [7:0]        m_byte_reg, m_byte_next;
    logic [LEN_W-1:0]  m_len_reg,  m_len_next;
    logic [SLOT_W-1:0] m_slot_reg, m_slot_next;

    logic              in_acc, adv, issue;
    logic [SLOT_W-1:0] wslot_w, rslot_w;
    logic [OFF_W-1:0]  woff_w;
    logic [LEN_W-1:0]  new_off;
    logic              line_done;
    logic [CNT_W-1:0]  wslot_inc, rslot_inc;
    logic [6:0]        cfg_size;
    logic [6:0]        cfg_count;

    logic              st_we, st_re;
    logic [ADDR_W-1:0] st_waddr, st_raddr;
    logic [7:0]        st_rdata;
    logic              ln_we, ln_re;
    logic [LEN_W-1:0]  ln_rdata;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE) && !p_vld_reg;
    assign in_acc    = s_tvalid && s_tready;
    assign adv       = p_vld_reg && (!m_vld_reg || m_tready);

    // configuration, saturated on write (line count from the low four data bits)
    assign cfg_size  = cfg_data[6:0];
    assign cfg_count = {3'b000, cfg_data[3:0]};

    always_comb begin
        size_next  = size_reg;
        count_next = count_reg;
        eol_next   = eol_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_LINE_SIZE: begin
                    if (cfg_size == 7'd0) begin
                        size_next = LEN_W'(1);
                    end else if (cfg_size > 7'(MAX_LINE_BYTES)) begin
                        size_next = LEN_W'(MAX_LINE_BYTES);
                    end else begin
                        size_next = LEN_W'(cfg_size);
                    end
                end
                CFG_LINE_COUNT: begin
                    if (cfg_count == 7'd0) begin
                        count_next = CNT_W'(1);
                    end else if (cfg_count > 7'(MAX_LINES)) begin
                        count_next = CNT_W'(MAX_LINES);
                    end else begin
                        count_next = CNT_W'(cfg_count);
                    end
                end
                CFG_EOL_CHAR: begin
                    eol_next = cfg_data[7:0];
                end
                default: begin
                end
            endcase
        end
    end

    // slot wrap, offset saturation
    assign wslot_w   = (CNT_W'(wslot_reg) >= count_reg) ? '0 : wslot_reg;
    assign rslot_w   = (CNT_W'(rslot_reg) >= count_reg) ? '0 : rslot_reg;
    assign woff_w    = (LEN_W'(woff_reg) >= size_reg) ? OFF_W'(size_reg - LEN_W'(1))
                                                      : woff_reg;
    assign new_off   = LEN_W'(woff_w) + LEN_W'(1);
    assign line_done = (s_tdata == eol_reg) || (new_off >= size_reg);
    assign wslot_inc = CNT_W'(wslot_w) + CNT_W'(1);
    assign rslot_inc = CNT_W'(rslot_w) + CNT_W'(1);

    assign st_we    = in_acc && (s_tuser == KIND_RX);
    assign st_waddr = ADDR_W'(wslot_w) * ADDR_W'(MAX_LINE_BYTES) + ADDR_W'(woff_w);
    assign ln_we    = st_we && line_done;
    assign ln_re    = in_acc && (s_tuser == KIND_TAKE) && valid_reg[rslot_w];

    assign issue    = (state_reg == ST_STREAM) && (!p_vld_reg || adv);
    assign st_re    = issue;
    assign st_raddr = ADDR_W'(oslot_reg) * ADDR_W'(MAX_LINE_BYTES)
                    + ADDR_W'(k_reg[OFF_W-1:0]);

    always_comb begin
        state_next  = state_reg;
        wslot_next  = wslot_reg;
        woff_next   = woff_reg;
        rslot_next  = rslot_reg;
        valid_next  = valid_reg;
        oslot_next  = oslot_reg;
        len_next    = len_reg;
        k_next      = k_reg;
        p_vld_next  = adv ? 1'b0 : p_vld_reg;
        p_none_next = p_none_reg;
        p_last_next = p_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && s_tuser == KIND_RX) begin
                    if (line_done) begin
                        valid_next[wslot_w] = 1'b1;
                        wslot_next = (wslot_inc >= count_reg) ? '0 : SLOT_W'(wslot_inc);
                        woff_next  = '0;
                    end else begin
                        wslot_next = wslot_w;
                        woff_next  = OFF_W'(new_off);
                    end
                end else if (in_acc) begin
                    if (valid_reg[rslot_w]) begin
                        valid_next[rslot_w] = 1'b0;
                        rslot_next = (rslot_inc >= count_reg) ? '0 : SLOT_W'(rslot_inc);
                        oslot_next = rslot_w;
                        state_next = ST_LEN;
                    end else begin
                        rslot_next  = rslot_w;
                        p_vld_next  = 1'b1;
                        p_none_next = 1'b1;
                        p_last_next = 1'b0;
                    end
                end
            end
            ST_LEN: begin
                len_next   = ln_rdata;
                k_next     = '0;
                state_next = ST_STREAM;
            end
            ST_STREAM: begin
                if (issue) begin
                    p_vld_next  = 1'b1;
                    p_none_next = 1'b0;
                    p_last_next = (k_reg + LEN_W'(1) == len_reg);
                    k_next      = k_reg + LEN_W'(1);
                    if (k_reg + LEN_W'(1) == len_reg) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        m_vld_next  = (m_vld_reg && !m_tready) || adv;
        m_none_next = m_none_reg;
        m_last_next = m_last_reg;
        m_byte_next = m_byte_reg;
        m_len_next  = m_len_reg;
        m_slot_next = m_slot_reg;
        if (adv) begin
            m_none_next = p_none_reg;
            m_last_next = p_last_reg;
            m_byte_next = p_none_reg ? 8'd0 : st_rdata;
            m_len_next  = p_none_reg ? '0 : len_reg;
            m_slot_next = p_none_reg ? '0 : oslot_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg   <= LEN_W'(RST_SIZE);
            count_reg  <= CNT_W'(RST_COUNT);
            eol_reg    <= 8'(EOL_CHAR_RESET);
            state_reg  <= ST_IDLE;
            wslot_reg  <= '0;
            woff_reg   <= '0;
            rslot_reg  <= '0;
            valid_reg  <= '0;
            p_vld_reg  <= 1'b0;
            m_vld_reg  <= 1'b0;
        end else begin
            size_reg   <= size_next;
            count_reg  <= count_next;
            eol_reg    <= eol_next;
            state_reg  <= state_next;
            wslot_reg  <= wslot_next;
            woff_reg   <= woff_next;
            rslot_reg  <= rslot_next;
            valid_reg  <= valid_next;
            p_vld_reg  <= p_vld_next;
            m_vld_reg  <= m_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        oslot_reg  <= oslot_next;
        len_reg    <= len_next;
        k_reg      <= k_next;
        p_none_reg <= p_none_next;
        p_last_reg <= p_last_next;
        m_none_reg <= m_none_next;
        m_last_reg <= m_last_next;
        m_byte_reg <= m_byte_next;
        m_len_reg  <= m_len_next;
        m_slot_reg <= m_slot_next;
    end

    urlbr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (s_tdata),
        .re    (st_re),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

    urlbr_ram #(
        .WIDTH (LEN_W),
        .DEPTH (MAX_LINES)
    ) u_lengths (
        .aclk  (aclk),
        .we    (ln_we),
        .waddr (wslot_w),
        .wdata (new_off),
        .re    (ln_re),
        .raddr (rslot_w),
        .rdata (ln_rdata)
    );

    assign m_tvalid = m_vld_reg;
    assign m_tuser  = m_none_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {{OUT_PAD_W{1'b0}}, SLOT_FIELD_W'(m_slot_reg),
                       LEN_FIELD_W'(m_len_reg), m_byte_reg};

endmodule

`default_nettype wire

FILE: sv/urlbr_checker.sv
// Port-level checker for the receive line buffer ring, bound to the top level.
// Depends on urlbr_pkg and uart_rx_line_buffer_ring_defines.svh.
`default_nettype none

`include "uart_rx_line_buffer_ring_defines.svh"

module urlbr_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_tready,
    input wire logic                               m_tvalid,
    input wire logic                               m_tready,
    input wire logic [urlbr_pkg::OUT_TDATA_W-1:0]  m_tdata,   // line_byte, line_length, line_slot, pad
    input wire logic                               m_tuser,   // none_ready
    input wire logic                               m_tlast    // last_byte
);

    import urlbr_pkg::*;

    logic line_res;
    logic mid_run;

    assign line_res = m_tvalid && !m_tuser;
    assign mid_run  = m_tvalid && !m_tuser && !m_tlast;

    `URLBR_ASSERT_IMP(a_none_is_blank, m_tvalid && m_tuser, !m_tlast && m_tdata == '0)
    `URLBR_ASSERT_IMP(a_line_has_len, line_res, m_tdata[BYTE_W +: LEN_FIELD_W] != '0)
    `URLBR_ASSERT_IMP(a_run_no_take, mid_run, !s_tready)
    `URLBR_ASSERT_NXT(a_stall_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind uart_rx_line_buffer_ring urlbr_checker u_urlbr_checker (.*);

`default_nettype wire
